// ===== rtl/quadrature_count_delta_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature count delta tracker
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_COUNT_DELTA_TRACKER_DEFINES_SVH
`define QUADRATURE_COUNT_DELTA_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define QCDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define QCDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// qcdt_pkg
// Types and constants shared by the quadrature count delta tracker.
// ----------------------------------------------------------------------------
package qcdt_pkg;

  typedef logic        [15:0] count_t;
  typedef logic signed [17:0] delta_t;
  typedef logic signed [31:0] position_t;
  typedef logic        [31:0] runtime_t;

  localparam count_t COUNT_MID    = 16'h7FFF;
  localparam count_t BAND_LOW     = 16'h4000;
  localparam count_t BAND_HIGH    = 16'hBFFE;
  localparam delta_t WRAP_SPAN    = 18'sh10000;
  localparam count_t PERIOD_RESET = 16'd1000;

endpackage

// ===== rtl/qcdt_channels.sv =====
// ----------------------------------------------------------------------------
// qcdt channels
// Valid/ready channels for counter ticks and tracker results.
// ----------------------------------------------------------------------------
interface qcdt_count_if;
  import qcdt_pkg::*;

  logic   valid;
  logic   ready;
  count_t counter_value;

  modport source (output valid, output counter_value, input ready);
  modport sink   (input valid, input counter_value, output ready);
endinterface

interface qcdt_result_if;
  import qcdt_pkg::*;

  logic      valid;
  logic      ready;
  logic      sample_taken;
  delta_t    step_delta;
  position_t position_total;
  runtime_t  runtime_tenths;

  modport source (output valid, output sample_taken, output step_delta,
                  output position_total, output runtime_tenths, input ready);
  modport sink   (input valid, input sample_taken, input step_delta,
                  input position_total, input runtime_tenths, output ready);
endinterface

// ===== rtl/qcdt_delta.sv =====
// ----------------------------------------------------------------------------
// qcdt_delta
// Signed count change between two samples with wrap detection.
// ----------------------------------------------------------------------------
module qcdt_delta (
  input  qcdt_pkg::count_t prev,
  input  qcdt_pkg::count_t cur,
  output qcdt_pkg::delta_t delta
);
  import qcdt_pkg::*;

  logic   centre;
  logic   fwd;
  logic   bwd;
  delta_t diff;

  assign centre = (cur >= BAND_LOW) && (cur <= BAND_HIGH) &&
                  (prev >= BAND_LOW) && (prev <= BAND_HIGH);
  assign fwd    = (prev > COUNT_MID) && (cur < COUNT_MID);
  assign bwd    = (prev < COUNT_MID) && (cur > COUNT_MID);
  assign diff   = delta_t'({2'b00, cur}) - delta_t'({2'b00, prev});

  // a crossing counts as a wrap only outside the centre band
  always_comb begin
    if (fwd && !centre) begin
      delta = diff + WRAP_SPAN;
    end else if (bwd && !centre) begin
      delta = diff - WRAP_SPAN;
    end else begin
      delta = diff;
    end
  end

endmodule

// ===== rtl/quadrature_count_delta_tracker.sv =====
// From tick accept to result valid a tick passes the input register, then the result register.
// Throughput: one tick per cycle while the result is not stalled; the short delta and accumulate path sets the rate.
// A stalled result holds the state update, and the input register takes one more tick.
// Reset: synchronous, active high; clears all state but in_count, sample_period returns to 1000.
// ----------------------------------------------------------------------------
// quadrature_count_delta_tracker
// Per-tick run-time prescaler, periodic delta sampling and position total.
// ----------------------------------------------------------------------------
module quadrature_count_delta_tracker #(
  parameter int RUNTIME_DIVIDE = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  qcdt_pkg::count_t     cfg_wr_data,
  qcdt_count_if.sink           in_ch,
  qcdt_result_if.source        out_ch
);
  import qcdt_pkg::*;

  localparam int PRE_W = $clog2(RUNTIME_DIVIDE + 1);
  localparam logic [PRE_W:0] DIV_CMP = (PRE_W + 1)'(RUNTIME_DIVIDE);

  count_t            sample_period;
  logic              in_valid;
  count_t            in_count;
  logic              out_valid;
  logic              out_taken;

  count_t            previous_count;
  logic              previous_valid;
  count_t            period_count;
  logic [PRE_W-1:0]  runtime_prescale;
  runtime_t          runtime_count;
  position_t         position_sum;
  delta_t            last_delta;

  logic              advance;
  logic              fire;
  logic [PRE_W:0]    prescale_inc;
  logic              prescale_wrap;
  count_t            period_next;
  logic              take;
  count_t            prev_eff;
  delta_t            delta;

  assign advance      = !out_valid || out_ch.ready;
  assign fire         = in_valid && advance;
  assign in_ch.ready  = !in_valid || advance;

  assign prescale_inc  = {1'b0, runtime_prescale} + (PRE_W + 1)'(1);
  assign prescale_wrap = prescale_inc >= DIV_CMP;
  assign period_next   = period_count + 16'd1;
  assign take          = period_next >= sample_period;
  // first tick compares against itself
  assign prev_eff      = previous_valid ? previous_count : in_count;

  qcdt_delta u_delta (
    .prev  (prev_eff),
    .cur   (in_count),
    .delta (delta)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      sample_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_count <= in_ch.counter_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      out_taken        <= 1'b0;
      previous_count   <= '0;
      previous_valid   <= 1'b0;
      period_count     <= '0;
      runtime_prescale <= '0;
      runtime_count    <= '0;
      position_sum     <= '0;
      last_delta       <= '0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        out_taken      <= take;
        previous_valid <= 1'b1;
        if (prescale_wrap) begin
          runtime_prescale <= '0;
          runtime_count    <= runtime_count + 32'd1;
        end else begin
          runtime_prescale <= prescale_inc[PRE_W-1:0];
        end
        if (take) begin
          period_count   <= '0;
          previous_count <= in_count;
          last_delta     <= delta;
          position_sum   <= position_sum + position_t'(delta);
        end else begin
          period_count   <= period_next;
          previous_count <= prev_eff;
        end
      end
    end
  end

  // state regs hold while the result waits, so they drive the fields directly
  assign out_ch.valid          = out_valid;
  assign out_ch.sample_taken   = out_taken;
  assign out_ch.step_delta     = last_delta;
  assign out_ch.position_total = position_sum;
  assign out_ch.runtime_tenths = runtime_count;

endmodule

// ===== rtl/qcdt_checker.sv =====
// ----------------------------------------------------------------------------
// qcdt_checker
// Port-level checks on the result stream of the delta tracker.
// ----------------------------------------------------------------------------
`include "quadrature_count_delta_tracker_defines.svh"

module qcdt_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               sample_taken,
  input qcdt_pkg::delta_t    step_delta,
  input qcdt_pkg::position_t position_total,
  input qcdt_pkg::runtime_t  runtime_tenths
);
  import qcdt_pkg::*;

  logic      seen;
  delta_t    seen_delta;
  position_t seen_pos;
  runtime_t  seen_runtime;
  logic      out_fire;

  assign out_fire = out_valid && out_ready;

  // remember the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_fire) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      seen_delta   <= step_delta;
      seen_pos     <= position_total;
      seen_runtime <= runtime_tenths;
    end
  end

  `QCDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position_total) && $stable(runtime_tenths), "result changed while stalled")
  `QCDT_ASSERT_NOW(a_runtime_step, out_fire && seen, runtime_tenths == seen_runtime || runtime_tenths == seen_runtime + 32'd1, "run time jumped by more than one")
  `QCDT_ASSERT_NOW(a_hold_no_sample, out_fire && seen && !sample_taken, position_total == seen_pos && step_delta == seen_delta, "position or delta moved without a sample")
  `QCDT_ASSERT_NOW(a_sum_tracks, out_fire && seen && sample_taken, position_total == seen_pos + position_t'(step_delta), "position total does not follow delta")

endmodule

bind quadrature_count_delta_tracker qcdt_checker u_qcdt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .sample_taken   (out_ch.sample_taken),
  .step_delta     (out_ch.step_delta),
  .position_total (out_ch.position_total),
  .runtime_tenths (out_ch.runtime_tenths)
);
